[hdl/csrmv_pkg.sv]
// Shared types and constants for the compressed-row sparse matrix-vector unit.
// Used by csrmv_ctrl, csrmv_dp and the top level; depends on nothing else.
`default_nettype none

package csrmv_pkg;

    // Fixed field widths of the item and result ports.
    localparam int REQ_W      = 2;
    localparam int IDX_W      = 10;
    localparam int VAL_W      = 32;
    localparam int PTR_W      = 32;
    localparam int ROWCNT_W   = 13;
    localparam int COLCNT_W   = 11;
    localparam int RIDX_W     = 12;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 13;
    // Wide enough for either parameter's full range.
    localparam int LIM_W      = 17;

    // Request type codes.
    localparam logic [REQ_W-1:0] REQ_LOAD = 2'd0;
    localparam logic [REQ_W-1:0] REQ_PTR  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_NZ   = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COL_COUNT = 1'd1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;     // store a vector entry
        logic ptr;      // handle a row pointer
        logic nz_read;  // capture a nonzero and read its vector entry
        logic mul;      // form the product
        logic acc;      // accumulate and finish the row if it is done
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic row_open;
    } t_dp_status;

endpackage

`default_nettype wire

[hdl/csr_sparse_matrix_vector_multiply_unit.sv]
// Top level of the compressed-row sparse matrix-vector unit.
// Joins csrmv_ctrl and csrmv_dp; depends on csrmv_pkg.
//
//   channel   direction  handshake               payload
//   item      in         start & !busy           i_req_type, i_x_index, i_entry_value,
//                                                i_ptr_value, i_ptr_first
//   result    out        o_valid, one cycle      o_row_index, o_row_sum
//   config    in         i_cfg_we                i_cfg_index, i_cfg_data
//
// A load or a row pointer item does not make the unit busy; the next item may follow at once.
// A nonzero item inside an open row goes through three steps: accept with the vector
// table read, the 32x32 multiply, then the accumulate; busy is high for the last two.
// A result appears on the cycle after the pointer or accumulate step that ends a row.
// Synchronous active-low reset clears the control, configuration, row tracking and
// strobe registers; the vector table has no reset and holds data only once loaded.
// Results cannot be held off: each strobe lasts exactly one cycle.
`default_nettype none

module csr_sparse_matrix_vector_multiply_unit #(
    parameter int VECTOR_DEPTH = 1024,
    parameter int ROW_LIMIT    = 4096
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire logic                                   start,
    output logic                                        busy,
    input  wire logic [csrmv_pkg::REQ_W-1:0]            i_req_type,
    input  wire logic [csrmv_pkg::IDX_W-1:0]            i_x_index,
    input  wire logic signed [csrmv_pkg::VAL_W-1:0]     i_entry_value,
    input  wire logic [csrmv_pkg::PTR_W-1:0]            i_ptr_value,
    input  wire logic                                   i_ptr_first,
    output logic                                        o_valid,
    output logic [csrmv_pkg::RIDX_W-1:0]                o_row_index,
    output logic signed [csrmv_pkg::VAL_W-1:0]          o_row_sum,
    input  wire logic                                   i_cfg_we,
    input  wire logic [csrmv_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  wire logic [csrmv_pkg::CFG_DATA_W-1:0]       i_cfg_data
);
    import csrmv_pkg::*;

    t_dp_cmd    cmd;
    t_dp_status status;

    csrmv_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .i_req_type (i_req_type),
        .i_status   (status),
        .o_cmd      (cmd),
        .busy       (busy)
    );

    csrmv_dp #(
        .VECTOR_DEPTH (VECTOR_DEPTH),
        .ROW_LIMIT    (ROW_LIMIT)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_status      (status),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_x_index     (i_x_index),
        .i_entry_value (i_entry_value),
        .i_ptr_value   (i_ptr_value),
        .i_ptr_first   (i_ptr_first),
        .o_valid       (o_valid),
        .o_row_index   (o_row_index),
        .o_row_sum     (o_row_sum)
    );

endmodule

`default_nettype wire

[hdl/csrmv_ctrl.sv]
// Controller state machine: accepts items and sequences a nonzero through
// table read, multiply and accumulate. Depends on csrmv_pkg.
`default_nettype none

module csrmv_ctrl (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         start,
    input  wire logic [1:0]                   i_req_type,
    input  wire csrmv_pkg::t_dp_status        i_status,
    output csrmv_pkg::t_dp_cmd                o_cmd,
    output logic                              busy
);
    import csrmv_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_MUL
    } t_state;

    t_state r_state, n_state;
    logic   r_busy, n_busy;
    logic   accept;
    logic   is_nz;

    assign accept = start && (r_state == S_IDLE);

    always_comb begin
        o_cmd   = '0;
        is_nz   = 1'b0;
        case (i_req_type)
            REQ_LOAD: o_cmd.load = accept;
            REQ_PTR:  o_cmd.ptr  = accept;
            REQ_NZ:   is_nz      = 1'b1;
            default:  is_nz      = 1'b0;
        endcase
        // A nonzero with no open row is dropped at acceptance.
        o_cmd.nz_read = accept && is_nz && i_status.row_open;
        o_cmd.mul     = (r_state == S_READ);
        o_cmd.acc     = (r_state == S_MUL);
    end

    always_comb begin
        n_state = r_state;
        n_busy  = r_busy;
        case (r_state)
            S_IDLE: begin
                if (o_cmd.nz_read) begin
                    n_state = S_READ;
                    n_busy  = 1'b1;
                end
            end
            S_READ: begin
                n_state = S_MUL;
                n_busy  = 1'b1;
            end
            S_MUL: begin
                n_state = S_IDLE;
                n_busy  = 1'b0;
            end
            default: begin
                n_state = S_IDLE;
                n_busy  = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_busy  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_busy  <= n_busy;
        end
    end

    assign busy = r_busy;

    a_read_then_mul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ) |=> (r_state == S_MUL))
        else $error("read step not followed by multiply step");

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> !(o_cmd.load || o_cmd.ptr || o_cmd.nz_read))
        else $error("item command issued while busy");

    a_busy_matches_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy == (r_state != S_IDLE))
        else $error("busy flag out of step with state");

endmodule

`default_nettype wire

[hdl/csrmv_dp.sv]
// Datapath: vector table memory, row pointer tracking, multiply-accumulate,
// configuration registers and the result register. Depends on csrmv_pkg.
`default_nettype none

module csrmv_dp #(
    parameter int VECTOR_DEPTH = 1024,
    parameter int ROW_LIMIT    = 4096
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire csrmv_pkg::t_dp_cmd                     i_cmd,
    output csrmv_pkg::t_dp_status                       o_status,
    input  wire logic                                   i_cfg_we,
    input  wire logic [csrmv_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  wire logic [csrmv_pkg::CFG_DATA_W-1:0]       i_cfg_data,
    input  wire logic [csrmv_pkg::IDX_W-1:0]            i_x_index,
    input  wire logic signed [csrmv_pkg::VAL_W-1:0]     i_entry_value,
    input  wire logic [csrmv_pkg::PTR_W-1:0]            i_ptr_value,
    input  wire logic                                   i_ptr_first,
    output logic                                        o_valid,
    output logic [csrmv_pkg::RIDX_W-1:0]                o_row_index,
    output logic signed [csrmv_pkg::VAL_W-1:0]          o_row_sum
);
    import csrmv_pkg::*;

    localparam int               AW       = $clog2(VECTOR_DEPTH);
    localparam logic [LIM_W-1:0] DEPTH_LIM = LIM_W'(VECTOR_DEPTH);
    localparam logic [LIM_W-1:0] ROW_LIM   = LIM_W'(ROW_LIMIT);

    logic [VAL_W-1:0] mem [VECTOR_DEPTH];

    logic [ROWCNT_W-1:0] r_row_count;
    logic [COLCNT_W-1:0] r_col_count;
    logic [PTR_W-1:0]    r_prev_ptr, n_prev_ptr;
    logic [ROWCNT_W-1:0] r_row_counter, n_row_counter;
    logic [PTR_W-1:0]    r_entries_left, n_entries_left;
    logic [VAL_W-1:0]    r_running_sum, n_running_sum;
    logic                r_out_valid, n_out_valid;
    logic [RIDX_W-1:0]   r_out_index, n_out_index;
    logic [VAL_W-1:0]    r_out_sum, n_out_sum;

    logic [VAL_W-1:0]    r_rdata;
    logic [VAL_W-1:0]    r_nz_val;
    logic                r_col_ok;
    logic [VAL_W-1:0]    r_prod;

    logic [AW-1:0]       addr;
    logic                idx_in_depth;
    logic [LIM_W-1:0]    row_limit;
    logic [PTR_W-1:0]    row_len;
    logic [PTR_W-1:0]    entries_dec;
    logic [VAL_W-1:0]    sum_add;
    logic [VAL_W-1:0]    x_sel;

    assign addr         = AW'(i_x_index);
    assign idx_in_depth = LIM_W'(i_x_index) < DEPTH_LIM;
    assign row_limit    = (LIM_W'(r_row_count) < ROW_LIM) ? LIM_W'(r_row_count) : ROW_LIM;
    assign row_len      = i_ptr_value - r_prev_ptr;
    assign entries_dec  = r_entries_left - PTR_W'(1);
    assign sum_add      = r_running_sum + r_prod;
    assign x_sel        = r_col_ok ? r_rdata : '0;

    assign o_status.row_open = (r_entries_left != '0);

    // Vector table: one write port for loads, one registered read for nonzeros.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load && idx_in_depth) begin
            mem[addr] <= $unsigned(i_entry_value);
        end
        if (i_cmd.nz_read) begin
            r_rdata <= mem[addr];
        end
    end

    // Payload registers of the multiply path.
    always_ff @(posedge i_clk) begin
        if (i_cmd.nz_read) begin
            r_nz_val <= $unsigned(i_entry_value);
            r_col_ok <= idx_in_depth && (COLCNT_W'(i_x_index) < r_col_count);
        end
        if (i_cmd.mul) begin
            r_prod <= r_nz_val * x_sel;
        end
    end

    always_comb begin
        n_prev_ptr     = r_prev_ptr;
        n_row_counter  = r_row_counter;
        n_entries_left = r_entries_left;
        n_running_sum  = r_running_sum;
        n_out_valid    = 1'b0;
        n_out_index    = r_out_index;
        n_out_sum      = r_out_sum;

        if (i_cmd.ptr) begin
            if (i_ptr_first) begin
                // The base pointer restarts the pass and drops any open row.
                n_prev_ptr     = i_ptr_value;
                n_row_counter  = '0;
                n_entries_left = '0;
                n_running_sum  = '0;
            end else if ((r_entries_left == '0) &&
                         (LIM_W'(r_row_counter) < row_limit)) begin
                n_prev_ptr = i_ptr_value;
                if (row_len == '0) begin
                    n_out_valid   = 1'b1;
                    n_out_index   = r_row_counter[RIDX_W-1:0];
                    n_out_sum     = '0;
                    n_row_counter = r_row_counter + ROWCNT_W'(1);
                end else begin
                    n_entries_left = row_len;
                    n_running_sum  = '0;
                end
            end
        end

        if (i_cmd.acc) begin
            n_running_sum  = sum_add;
            n_entries_left = entries_dec;
            if (entries_dec == '0) begin
                n_out_valid   = 1'b1;
                n_out_index   = r_row_counter[RIDX_W-1:0];
                n_out_sum     = sum_add;
                n_row_counter = r_row_counter + ROWCNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_count    <= '0;
            r_col_count    <= '0;
            r_prev_ptr     <= '0;
            r_row_counter  <= '0;
            r_entries_left <= '0;
            r_running_sum  <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_ROW_COUNT: r_row_count <= i_cfg_data[ROWCNT_W-1:0];
                    CFG_COL_COUNT: r_col_count <= i_cfg_data[COLCNT_W-1:0];
                    default: ;
                endcase
            end
            r_prev_ptr     <= n_prev_ptr;
            r_row_counter  <= n_row_counter;
            r_entries_left <= n_entries_left;
            r_running_sum  <= n_running_sum;
            r_out_valid    <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_index <= n_out_index;
        r_out_sum   <= n_out_sum;
    end

    assign o_valid     = r_out_valid;
    assign o_row_index = r_out_index;
    assign o_row_sum   = $signed(r_out_sum);

    a_result_has_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> $past(i_cmd.acc || i_cmd.ptr))
        else $error("result strobe without a pointer or accumulate step");

    a_acc_row_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.acc |-> (r_entries_left != '0))
        else $error("accumulate step with no open row");

    a_row_advances: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_row_counter == $past(r_row_counter) + ROWCNT_W'(1)))
        else $error("row counter did not advance with a result");

endmodule

`default_nettype wire
